// ===== sv/half_duplex_uart_transceiver_defines.svh =====
// Assertion macros used by the checker of the half-duplex UART transceiver.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef HALF_DUPLEX_UART_TRANSCEIVER_DEFINES_SVH
`define HALF_DUPLEX_UART_TRANSCEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HDUT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HDUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hdut_pkg.sv =====
// Package for the half-duplex UART transceiver: register indexes, stream
// field positions, timer widths and the bit-period conversion. No dependencies.
`timescale 1ns / 1ps

package hdut_pkg;

    localparam int TIMER_W  = 12;
    localparam int COUNT_W  = 16;
    localparam int BTIME_W  = 13;
    localparam int CFG_W    = 16;

    typedef logic [0:0]         cfg_idx_t;
    typedef logic [TIMER_W-1:0] timer_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam cfg_idx_t CFG_BIT_TIME  = 1'b0;
    localparam cfg_idx_t CFG_RX_LENGTH = 1'b1;

    // Slave tdata layout.
    localparam int IN_W          = 16;
    localparam int IN_LEVEL_BIT  = 0;
    localparam int IN_REQ_BIT    = 1;
    localparam int IN_BYTE_LSB   = 2;

    // Master tdata layout.
    localparam int OUT_W         = 32;
    localparam int OUT_TX_BIT    = 0;
    localparam int OUT_BUSY_BIT  = 1;
    localparam int OUT_BYTE_LSB  = 2;
    localparam int OUT_INDEX_LSB = 10;
    localparam int OUT_USED_W    = 26;

    // Ticks per interval minus one: ((us * 5) >> 4), with zero treated as one tick.
    function automatic timer_t ticks_m1(input logic [BTIME_W:0] us);
        logic [15:0]  prod;
        timer_t       t;
        prod = {2'b00, us} + {us, 2'b00};
        t    = prod[15:4];
        return (t == '0) ? '0 : t - timer_t'(1);
    endfunction

    function automatic logic [BTIME_W:0] first_us(input logic [BTIME_W-1:0] bt);
        return {1'b0, bt} + {2'b00, bt[BTIME_W-1:1]};
    endfunction

    localparam logic [BTIME_W-1:0] BIT_TIME_RESET  = 13'd26;
    localparam count_t             RX_LENGTH_RESET = 16'd1;
    localparam timer_t PERIOD_M1_RESET = ticks_m1({1'b0, BIT_TIME_RESET});
    localparam timer_t FIRST_M1_RESET  = ticks_m1(first_us(BIT_TIME_RESET));

endpackage

// ===== sv/half_duplex_uart_transceiver.sv =====
// Half-duplex UART transceiver: an input transfer's result is registered and shows on
// the master side in the cycle after; one item per cycle is sustained while m_tready
// is high, set by the single output register that s_tready looks through.
// Bit timers are preloaded from values worked out at each configuration write.
// rst_n (asynchronous, active low) idles both directions, arms the receiver,
// and restores bit_time_us 26 and rx_length 1.
`timescale 1ns / 1ps

module half_duplex_uart_transceiver
    import hdut_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // rx_level [0], send_request [1], send_byte [9:2], zero [15:10]
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tx_level [0], send_busy [1], rx_byte [9:2], byte_index [25:10], zero [31:26]
    output logic [OUT_W-1:0]      m_tdata,
    // byte_valid [0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int PHASE_W = $clog2(DATA_BITS + 3);
    localparam int RX_TOP  = ((DATA_BITS > 8) ? 8 : DATA_BITS) - 1;

    localparam logic [PHASE_W-1:0] PH_IDLE  = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_START = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_DATA0 = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(DATA_BITS);
    localparam logic [PHASE_W-1:0] PH_STOP  = PHASE_W'(DATA_BITS + 2);

    // Configuration.
    timer_t             period_m1_reg;
    timer_t             first_m1_reg;
    count_t             rx_length_reg;

    // Transmitter and receiver state.
    logic [PHASE_W-1:0] tx_phase_reg, tx_phase_next;
    logic [7:0]         tx_shift_reg, tx_shift_next;
    timer_t             tx_timer_reg, tx_timer_next;
    logic [PHASE_W-1:0] rx_phase_reg, rx_phase_next;
    logic [7:0]         rx_shift_reg, rx_shift_next;
    timer_t             rx_timer_reg, rx_timer_next;
    count_t             rx_count_reg, rx_count_next;
    logic               rx_last_reg, rx_armed_reg, rx_armed_next;

    // Result register.
    logic               out_valid_reg;
    logic               tx_level_reg, tx_level_next;
    logic               busy_reg, busy_next;
    logic               byte_valid_reg, byte_valid_next;
    logic [7:0]         rx_byte_reg, rx_byte_next;
    count_t             index_reg, index_next;
    logic               done_reg, done_next;

    logic               in_accept;
    logic               level, req;
    logic [7:0]         send_byte;
    logic               cfg_write;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign level     = s_tdata[IN_LEVEL_BIT];
    assign req       = s_tdata[IN_REQ_BIT];
    assign send_byte = s_tdata[IN_BYTE_LSB +: 8];

    always_comb
    begin
        tx_phase_next   = tx_phase_reg;
        tx_shift_next   = tx_shift_reg;
        tx_timer_next   = tx_timer_reg;
        rx_phase_next   = rx_phase_reg;
        rx_shift_next   = rx_shift_reg;
        rx_timer_next   = rx_timer_reg;
        rx_count_next   = rx_count_reg;
        rx_armed_next   = rx_armed_reg;
        byte_valid_next = 1'b0;
        rx_byte_next    = 8'd0;
        index_next      = '0;
        done_next       = 1'b0;

        // Transmitter advances first.
        if (tx_phase_reg != PH_IDLE) begin
            if (tx_timer_reg == '0) begin
                if (tx_phase_reg >= PH_DATA0 && tx_phase_reg < PH_STOP) begin
                    tx_shift_next = tx_shift_reg >> 1;
                end
                tx_phase_next = (tx_phase_reg >= PH_STOP) ? PH_IDLE
                                                          : tx_phase_reg + PHASE_W'(1);
                tx_timer_next = period_m1_reg;
            end else begin
                tx_timer_next = tx_timer_reg - timer_t'(1);
            end
        end
        if (tx_phase_next == PH_IDLE) begin
            tx_timer_next = '0;
        end
        // A request starts only when both directions are quiet.
        if (req && tx_phase_next == PH_IDLE && rx_phase_reg == PH_IDLE) begin
            tx_phase_next = PH_START;
            tx_shift_next = send_byte;
            tx_timer_next = period_m1_reg;
        end

        // Receiver.
        if (rx_phase_reg != PH_IDLE) begin
            if (rx_timer_reg != '0) begin
                rx_timer_next = rx_timer_reg - timer_t'(1);
            end else if (rx_phase_reg <= PH_LAST) begin
                rx_shift_next         = rx_shift_reg >> 1;
                rx_shift_next[RX_TOP] = level;
                rx_phase_next         = rx_phase_reg + PHASE_W'(1);
                rx_timer_next         = period_m1_reg;
            end else begin
                // Middle of the stop bit: hand the byte over.
                byte_valid_next = 1'b1;
                rx_byte_next    = rx_shift_reg;
                index_next      = rx_count_reg;
                rx_count_next   = rx_count_reg + count_t'(1);
                if (rx_count_next == rx_length_reg) begin
                    done_next     = 1'b1;
                    rx_armed_next = 1'b0;
                end
                rx_phase_next = PH_IDLE;
                rx_timer_next = '0;
            end
        end else if (rx_armed_reg && tx_phase_next == PH_IDLE && rx_last_reg && !level) begin
            rx_phase_next = PH_START;
            rx_shift_next = 8'd0;
            rx_timer_next = first_m1_reg;
        end

        if (tx_phase_next == PH_START) begin
            tx_level_next = 1'b0;
        end else if (tx_phase_next >= PH_DATA0 && tx_phase_next < PH_STOP) begin
            tx_level_next = tx_shift_next[0];
        end else begin
            tx_level_next = 1'b1;
        end
        busy_next = (tx_phase_next != PH_IDLE) || (rx_phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            period_m1_reg <= PERIOD_M1_RESET;
            first_m1_reg  <= FIRST_M1_RESET;
            rx_length_reg <= RX_LENGTH_RESET;
            tx_phase_reg  <= PH_IDLE;
            tx_shift_reg  <= 8'd0;
            tx_timer_reg  <= '0;
            rx_phase_reg  <= PH_IDLE;
            rx_shift_reg  <= 8'd0;
            rx_timer_reg  <= '0;
            rx_count_reg  <= '0;
            rx_last_reg   <= 1'b1;
            rx_armed_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                tx_phase_reg  <= tx_phase_next;
                tx_shift_reg  <= tx_shift_next;
                tx_timer_reg  <= tx_timer_next;
                rx_phase_reg  <= rx_phase_next;
                rx_shift_reg  <= rx_shift_next;
                rx_timer_reg  <= rx_timer_next;
                rx_count_reg  <= rx_count_next;
                rx_last_reg   <= level;
                rx_armed_reg  <= rx_armed_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                case (cfg_index)
                    CFG_BIT_TIME:
                    begin
                        period_m1_reg <= ticks_m1({1'b0, cfg_data[BTIME_W-1:0]});
                        first_m1_reg  <= ticks_m1(first_us(cfg_data[BTIME_W-1:0]));
                    end
                    CFG_RX_LENGTH:
                    begin
                        rx_length_reg <= cfg_data;
                        rx_count_reg  <= '0;
                        rx_armed_reg  <= 1'b1;
                    end
                    default:
                    begin
                        rx_length_reg <= rx_length_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            tx_level_reg   <= tx_level_next;
            busy_reg       <= busy_next;
            byte_valid_reg <= byte_valid_next;
            rx_byte_reg    <= rx_byte_next;
            index_reg      <= index_next;
            done_reg       <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - OUT_USED_W)'(0), index_reg, rx_byte_reg, busy_reg,
                       tx_level_reg};
    assign m_tuser  = byte_valid_reg;
    assign m_tlast  = done_reg;

endmodule

// ===== sv/hdut_checker.sv =====
// Port-level checker for the half-duplex UART transceiver, bound to the top level.
// Depends on hdut_pkg and half_duplex_uart_transceiver_defines.svh.
`timescale 1ns / 1ps
`include "half_duplex_uart_transceiver_defines.svh"

module hdut_checker
    import hdut_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast
);

    // A completed run is only ever flagged together with a received byte.
    `HDUT_ASSERT_SAME(a_done_with_byte, m_tvalid && m_tlast, m_tuser, "rx_done without byte_valid")

    // Without a received byte the byte and index fields read as zero.
    `HDUT_ASSERT_SAME(a_idle_fields_zero, m_tvalid && !m_tuser, m_tdata[OUT_USED_W-1:OUT_BYTE_LSB] == '0, "byte fields set without byte_valid")

    // A low transmit line means a frame is in flight, so the block reports busy.
    `HDUT_ASSERT_SAME(a_low_line_busy, m_tvalid && !m_tdata[OUT_TX_BIT], m_tdata[OUT_BUSY_BIT], "tx line low while not busy")

    // A stalled result keeps its contents until the transfer.
    `HDUT_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

endmodule

bind half_duplex_uart_transceiver hdut_checker u_hdut_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
